// ===== rtl/core/x86sf_pkg.sv =====
// Shared types, operation codes and helpers for the x86 status flag unit.
// No dependencies; used by x86sf_flag_calc and x86_status_flag_unit.
package x86sf_pkg;

    // Operation classes
    localparam logic [3:0] FUNC_ADD   = 4'd0;
    localparam logic [3:0] FUNC_SUB   = 4'd1;
    localparam logic [3:0] FUNC_NEG   = 4'd2;
    localparam logic [3:0] FUNC_MUL   = 4'd3;
    localparam logic [3:0] FUNC_IMUL  = 4'd4;
    localparam logic [3:0] FUNC_LOGIC = 4'd5;
    localparam logic [3:0] FUNC_SHL   = 4'd6;
    localparam logic [3:0] FUNC_SHR   = 4'd7;
    localparam logic [3:0] FUNC_SAR   = 4'd8;
    localparam logic [3:0] FUNC_ROL   = 4'd9;
    localparam logic [3:0] FUNC_ROR   = 4'd10;
    localparam logic [3:0] FUNC_RCL   = 4'd11;

    // Operand width codes
    localparam logic [1:0] WSEL_8  = 2'd0;
    localparam logic [1:0] WSEL_16 = 2'd1;
    localparam logic [1:0] WSEL_32 = 2'd2;
    localparam logic [1:0] WSEL_64 = 2'd3;

    localparam int DATA_W  = 64;
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 8;

    // Flag set, CF in bit 0 up to OF in bit 5
    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic af;
        logic pf;
        logic cf;
    } flags_t;

    // One decoded input item
    typedef struct packed {
        logic [3:0]        func;
        logic [1:0]        width_sel;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] result_value;
        logic              result_extra_bit;
        logic [DATA_W-1:0] product_high;
    } item_t;

    // Mask of the active operand width
    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wsel);
        logic [DATA_W-1:0] m;
        unique case (wsel)
            WSEL_8:  m = 64'h0000_0000_0000_00FF;
            WSEL_16: m = 64'h0000_0000_0000_FFFF;
            WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    // Bit W-1 of x
    function automatic logic msb_bit(input logic [DATA_W-1:0] x, input logic [1:0] wsel);
        logic b;
        unique case (wsel)
            WSEL_8:  b = x[7];
            WSEL_16: b = x[15];
            WSEL_32: b = x[31];
            default: b = x[63];
        endcase
        return b;
    endfunction

    // Bit W-2 of x
    function automatic logic msb2_bit(input logic [DATA_W-1:0] x, input logic [1:0] wsel);
        logic b;
        unique case (wsel)
            WSEL_8:  b = x[6];
            WSEL_16: b = x[14];
            WSEL_32: b = x[30];
            default: b = x[62];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/x86sf_flag_calc.sv =====
// Combinational flag computation for one instruction item.
// Depends on x86sf_pkg (item_t, flags_t, codes, width helpers).
module x86sf_flag_calc (
    input  x86sf_pkg::item_t  item,
    input  x86sf_pkg::flags_t flags_cur,
    output x86sf_pkg::flags_t flags_new
);

    logic [63:0] mask;
    logic [63:0] a_m;
    logic [63:0] b_m;
    logic [63:0] r_m;
    logic [63:0] hi_m;
    logic [63:0] sext;
    logic [6:0]  w;
    logic [6:0]  cnt;
    logic [6:0]  shl_idx;
    logic [6:0]  shr_idx;
    logic        rs;
    logic        a_msb;
    logic        cnt_nz;
    logic        cnt_one;
    logic        res_flags;
    logic [63:0] axbxr;

    // Masked operands and shift count
    always_comb begin
        mask    = x86sf_pkg::width_mask(item.width_sel);
        a_m     = item.operand_a & mask;
        b_m     = item.operand_b & mask;
        r_m     = item.result_value & mask;
        hi_m    = item.product_high & mask;
        w       = 7'd8 << item.width_sel;
        cnt     = (item.width_sel == x86sf_pkg::WSEL_64) ? {1'b0, item.operand_b[5:0]}
                                                        : {2'b00, item.operand_b[4:0]};
        shl_idx = w - cnt;
        shr_idx = cnt - 7'd1;
        rs      = x86sf_pkg::msb_bit(r_m, item.width_sel);
        a_msb   = x86sf_pkg::msb_bit(a_m, item.width_sel);
        sext    = rs ? mask : 64'd0;
        cnt_nz  = (cnt != 7'd0);
        cnt_one = (cnt == 7'd1);
        axbxr   = a_m ^ b_m ^ r_m;
    end

    // Per-class update; kept flags pass through
    always_comb begin
        flags_new = flags_cur;
        res_flags = 1'b0;
        unique case (item.func)
            x86sf_pkg::FUNC_ADD: begin
                flags_new.cf = (r_m < a_m);
                flags_new.of = x86sf_pkg::msb_bit((a_m ^ ~b_m) & (a_m ^ r_m), item.width_sel);
                flags_new.af = axbxr[4];
                res_flags    = 1'b1;
            end
            x86sf_pkg::FUNC_SUB: begin
                flags_new.cf = x86sf_pkg::msb_bit(axbxr ^ ((a_m ^ r_m) & (a_m ^ b_m)),
                                                  item.width_sel);
                flags_new.of = x86sf_pkg::msb_bit((a_m ^ b_m) & (a_m ^ r_m), item.width_sel);
                flags_new.af = axbxr[4];
                res_flags    = 1'b1;
            end
            x86sf_pkg::FUNC_NEG: begin
                flags_new.cf = (a_m != 64'd0);
                flags_new.of = x86sf_pkg::msb_bit(a_m & r_m, item.width_sel);
                flags_new.af = a_m[4] ^ r_m[4];
                res_flags    = 1'b1;
            end
            x86sf_pkg::FUNC_MUL: begin
                flags_new.cf = (hi_m != 64'd0);
                flags_new.of = (hi_m != 64'd0);
            end
            x86sf_pkg::FUNC_IMUL: begin
                flags_new.cf = (hi_m != sext);
                flags_new.of = (hi_m != sext);
            end
            x86sf_pkg::FUNC_LOGIC: begin
                flags_new.cf = 1'b0;
                flags_new.of = 1'b0;
                res_flags    = 1'b1;
            end
            x86sf_pkg::FUNC_SHL: begin
                if (cnt_nz) begin
                    flags_new.cf = (cnt <= w) ? a_m[shl_idx[5:0]] : 1'b0;
                    if (cnt_one) begin
                        flags_new.of = a_msb ^ x86sf_pkg::msb2_bit(a_m, item.width_sel);
                    end
                    res_flags = 1'b1;
                end
            end
            x86sf_pkg::FUNC_SHR: begin
                if (cnt_nz) begin
                    flags_new.cf = (cnt <= w) ? a_m[shr_idx[5:0]] : 1'b0;
                    if (cnt_one) begin
                        flags_new.of = a_msb;
                    end
                    res_flags = 1'b1;
                end
            end
            x86sf_pkg::FUNC_SAR: begin
                if (cnt_nz) begin
                    flags_new.cf = (cnt < w) ? a_m[shr_idx[5:0]] : a_msb;
                    if (cnt_one) begin
                        flags_new.of = 1'b0;
                    end
                    res_flags = 1'b1;
                end
            end
            x86sf_pkg::FUNC_ROL: begin
                if (cnt_nz) begin
                    flags_new.cf = r_m[0];
                    if (cnt_one) begin
                        flags_new.of = rs ^ r_m[0];
                    end
                end
            end
            x86sf_pkg::FUNC_ROR: begin
                if (cnt_nz) begin
                    flags_new.cf = rs;
                    if (cnt_one) begin
                        flags_new.of = rs ^ x86sf_pkg::msb2_bit(r_m, item.width_sel);
                    end
                end
            end
            x86sf_pkg::FUNC_RCL: begin
                if (cnt_nz) begin
                    flags_new.cf = item.result_extra_bit;
                    if (cnt_one) begin
                        flags_new.of = rs ^ item.result_extra_bit;
                    end
                end
            end
            default: begin
                // undefined class: nothing changes
            end
        endcase

        // Result-derived flags
        if (res_flags) begin
            flags_new.pf = ~^r_m[7:0];
            flags_new.zf = (r_m == 64'd0);
            flags_new.sf = rs;
        end
    end

endmodule

// ===== rtl/core/x86_status_flag_unit.sv =====
// Top level of the x86 status flag unit: input register, flag register, stream handshakes.
// Depends on x86sf_pkg and x86sf_flag_calc.
//
// Usage:
//   The slave channel (s_axis_*) carries one executed instruction per item: operation
//   class, operand width, operands, result, extra result bit and product high half.
//   The master channel (m_axis_*) returns one item per input item: the full new flag
//   set CF, PF, AF, ZF, SF, OF in bits 0..5 of m_axis_tdata.
//   An accepted item is held in the input register and then moves into the flag register,
//   which raises m_axis_tvalid. Throughput is one item per cycle while m_axis_tready
//   stays high: the input register feeds the flag logic, and the flag register doubles
//   as the output register, so a new item is taken while the previous result waits.
//   The flag register holds the only flag state; each item's kept flags come from the
//   result of the item before it, so items are processed strictly in order.
//   When m_axis_tready is low with a result pending, one more item is held in the
//   input register and s_axis_tready drops until the result is taken.
//   Reset (aresetn low, synchronous) clears the flags to zero and empties both
//   stages; no item is emitted for the reset itself.
module x86_status_flag_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // func[3:0], width_sel[5:4], operand_a[69:6], operand_b[133:70],
    // result_value[197:134], result_extra_bit[198], product_high[262:199], zero[263]
    input  logic [x86sf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // carry_flag[0], parity_flag[1], adjust_flag[2], zero_flag[3],
    // sign_flag[4], overflow_flag[5], zero[7:6]
    output logic [x86sf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic              in_valid_reg;
    logic              in_valid_next;
    x86sf_pkg::item_t  in_item_reg;
    x86sf_pkg::item_t  s_item;
    logic              out_valid_reg;
    logic              out_valid_next;
    x86sf_pkg::flags_t flag_reg;
    x86sf_pkg::flags_t flag_next;
    x86sf_pkg::flags_t calc_flags;
    logic              advance;
    logic              s_accept;

    // Unpack the slave payload
    always_comb begin
        s_item.func             = s_axis_tdata[3:0];
        s_item.width_sel        = s_axis_tdata[5:4];
        s_item.operand_a        = s_axis_tdata[69:6];
        s_item.operand_b        = s_axis_tdata[133:70];
        s_item.result_value     = s_axis_tdata[197:134];
        s_item.result_extra_bit = s_axis_tdata[198];
        s_item.product_high     = s_axis_tdata[262:199];
    end

    // Handshake control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((out_valid_reg && m_axis_tready) ? 1'b0
                                                                           : out_valid_reg);
        flag_next      = advance ? calc_flags : flag_reg;
    end

    // Flag logic
    x86sf_flag_calc u_calc (
        .item      (in_item_reg),
        .flags_cur (flag_reg),
        .flags_new (calc_flags)
    );

    // Control and flag state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    // Input payload register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, flag_reg};

    // Flags change only when an item moves into the output stage
    a_flags_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(flag_reg))
        else $error("flag register changed without an item advancing");

    // Multiply classes leave PF, AF, ZF and SF alone
    a_mul_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_item_reg.func == x86sf_pkg::FUNC_MUL ||
                     in_item_reg.func == x86sf_pkg::FUNC_IMUL))
        |=> ($stable(flag_reg.pf) && $stable(flag_reg.af) &&
             $stable(flag_reg.zf) && $stable(flag_reg.sf)))
        else $error("multiply altered a result flag");

    // A pending result that is stalled keeps the input stage from overrunning it
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_axis_tready && in_valid_reg) |-> !s_axis_tready)
        else $error("input accepted while both stages are full and stalled");

endmodule
